[sv/swfl_pkg.sv]
package swfl_pkg;

    localparam int USERS_DEF     = 256;
    localparam int LOG_DEPTH_DEF = 16;

    localparam int OP_W     = 2;
    localparam int USER_W   = 8;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 3;
    localparam int MAX_W    = 4;
    localparam int SEC_W    = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [MAX_W-1:0] MSG_LIMIT_RST      = 4'd5;
    localparam logic [SEC_W-1:0] WINDOW_SECONDS_RST = 17'd10;
    localparam logic [SEC_W-1:0] MUTE_SECONDS_RST   = 17'd60;

    typedef enum logic [OP_W-1:0] {
        OP_CHAT  = 2'd0,
        OP_CHECK = 2'd1,
        OP_LOGIN = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_PASSED    = 3'd0,
        ST_BLOCKED   = 3'd1,
        ST_MUTED_NOW = 3'd2,
        ST_UNMUTED   = 3'd3,
        ST_NO_CHANGE = 3'd4,
        ST_RESTORED  = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MSG_LIMIT      = 2'd0,
        CFG_WINDOW_SECONDS = 2'd1,
        CFG_MUTE_SECONDS   = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_DECIDE,
        S_POP_RD,
        S_POP_CHK,
        S_APPEND,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic load_item;
        logic load_user;
        logic pop_chk;
        logic append;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic path_chat;
        logic count_zero;
        logic count_one;
        logic expired;
        logic out_free;
    } t_stat;

endpackage

[sv/per_user_sliding_window_flood_limiter_unit.sv]
// Per-user chat flood limiter.
// Input channel (i_in_valid / o_in_stall): one word per event carrying op
// (chat, expiry check, login), user index, current time and two flags.
// Output channel (o_out_valid / i_out_stall): one word per event with a
// status code and the user's stored mute expiry (0 when not muted).
// Config channel (i_cfg_valid / o_cfg_ready, always ready): register index
// and data; write only while no event is in flight.
// Events are handled one at a time. Checks, logins, exempt and blocked chat
// pass through load, decide and commit. A chat from an unmuted user also
// appends its stamp; with a non-empty log it first walks the stamp memory
// from the oldest stamp, a read state then a check state per stamp, dropping
// stamps that have aged out.
// After reset the per-user table is cleared at one user per cycle, with
// o_in_stall high; config writes are taken during that pass.
// The result sits in an output register: while the receiver stalls it holds,
// and the next event is accepted but its result waits until the word is taken.
module per_user_sliding_window_flood_limiter_unit #(
    parameter int USERS     = swfl_pkg::USERS_DEF,
    parameter int LOG_DEPTH = swfl_pkg::LOG_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [swfl_pkg::OP_W-1:0]       i_op,
    input  logic [swfl_pkg::USER_W-1:0]     i_user_index,
    input  logic [swfl_pkg::TIME_W-1:0]     i_now_seconds,
    input  logic                            i_mute_mark_present,
    input  logic                            i_exempt,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [swfl_pkg::STATUS_W-1:0]   o_status,
    output logic [swfl_pkg::TIME_W-1:0]     o_mute_until,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [swfl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [swfl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    swfl_pkg::t_cmd  cmd;
    swfl_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    swfl_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_stat    (stat),
        .o_in_stall(o_in_stall),
        .o_cmd     (cmd)
    );

    swfl_dp #(
        .USERS    (USERS),
        .LOG_DEPTH(LOG_DEPTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_op               (i_op),
        .i_user_index       (i_user_index),
        .i_now_seconds      (i_now_seconds),
        .i_mute_mark_present(i_mute_mark_present),
        .i_exempt           (i_exempt),
        .i_cfg_we           (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_status           (o_status),
        .o_mute_until       (o_mute_until)
    );

endmodule

[sv/swfl_ram.sv]
module swfl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/swfl_ctrl.sv]
module swfl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  swfl_pkg::t_stat i_stat,
    output logic            o_in_stall,
    output swfl_pkg::t_cmd  o_cmd
);

    swfl_pkg::t_state r_state;
    swfl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swfl_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            swfl_pkg::S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = swfl_pkg::S_IDLE;
                end
            end
            swfl_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = swfl_pkg::S_LOAD;
                end
            end
            swfl_pkg::S_LOAD: begin
                o_cmd.load_user = 1'b1;
                n_state         = swfl_pkg::S_DECIDE;
            end
            swfl_pkg::S_DECIDE: begin
                if (!i_stat.path_chat) begin
                    n_state = swfl_pkg::S_COMMIT;
                end else if (i_stat.count_zero) begin
                    n_state = swfl_pkg::S_APPEND;
                end else begin
                    n_state = swfl_pkg::S_POP_RD;
                end
            end
            swfl_pkg::S_POP_RD: begin
                n_state = swfl_pkg::S_POP_CHK;
            end
            swfl_pkg::S_POP_CHK: begin
                o_cmd.pop_chk = 1'b1;
                // keep walking while the oldest stamp has aged out and is not the last one
                if (i_stat.expired && !i_stat.count_one) begin
                    n_state = swfl_pkg::S_POP_RD;
                end else begin
                    n_state = swfl_pkg::S_APPEND;
                end
            end
            swfl_pkg::S_APPEND: begin
                o_cmd.append = 1'b1;
                n_state      = swfl_pkg::S_COMMIT;
            end
            swfl_pkg::S_COMMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = swfl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = swfl_pkg::S_CLEAR;
            end
        endcase
    end

endmodule

[sv/swfl_dp.sv]
module swfl_dp #(
    parameter int USERS     = swfl_pkg::USERS_DEF,
    parameter int LOG_DEPTH = swfl_pkg::LOG_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  swfl_pkg::t_cmd                  i_cmd,
    output swfl_pkg::t_stat                 o_stat,
    input  logic [swfl_pkg::OP_W-1:0]       i_op,
    input  logic [swfl_pkg::USER_W-1:0]     i_user_index,
    input  logic [swfl_pkg::TIME_W-1:0]     i_now_seconds,
    input  logic                            i_mute_mark_present,
    input  logic                            i_exempt,
    input  logic                            i_cfg_we,
    input  logic [swfl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [swfl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output logic [swfl_pkg::STATUS_W-1:0]   o_status,
    output logic [swfl_pkg::TIME_W-1:0]     o_mute_until
);

    localparam int UW     = (USERS > 1) ? $clog2(USERS) : 1;
    localparam int HW     = $clog2(LOG_DEPTH);
    localparam int CW     = $clog2(LOG_DEPTH + 1);
    localparam int TW     = swfl_pkg::TIME_W;
    localparam int RECW   = HW + CW + 1 + TW;
    localparam int SDEPTH = USERS * LOG_DEPTH;
    localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int CMPW   = (CW > swfl_pkg::MAX_W) ? CW : swfl_pkg::MAX_W;
    localparam int NMAP   = 2 ** swfl_pkg::USER_W;

    // user index folded onto the user count
    logic [UW-1:0] user_map [NMAP];
    for (genvar g = 0; g < NMAP; g++) begin : g_map
        assign user_map[g] = UW'(g % USERS);
    end

    logic [swfl_pkg::MAX_W-1:0] r_max;
    logic [swfl_pkg::SEC_W-1:0] r_window;
    logic [swfl_pkg::SEC_W-1:0] r_mute;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max    <= swfl_pkg::MSG_LIMIT_RST;
            r_window <= swfl_pkg::WINDOW_SECONDS_RST;
            r_mute   <= swfl_pkg::MUTE_SECONDS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                swfl_pkg::CFG_MSG_LIMIT:      r_max    <= i_cfg_data[swfl_pkg::MAX_W-1:0];
                swfl_pkg::CFG_WINDOW_SECONDS: r_window <= i_cfg_data;
                swfl_pkg::CFG_MUTE_SECONDS:   r_mute   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [swfl_pkg::OP_W-1:0] r_op;
    logic [UW-1:0]             r_user;
    logic [TW-1:0]             r_now;
    logic                      r_mark;
    logic                      r_exempt;
    logic [HW-1:0]             r_head;
    logic [CW-1:0]             r_count;
    logic                      r_valid;
    logic [TW-1:0]             r_exp;
    logic [UW-1:0]             r_clr;

    logic [RECW-1:0] user_rdata;
    logic [RECW-1:0] user_wdata;
    logic [UW-1:0]   user_waddr;
    logic            user_we;
    logic [TW-1:0]   stamp_rdata;
    logic [SAW-1:0]  stamp_waddr;
    logic [SAW-1:0]  stamp_raddr;

    // ring slot arithmetic
    logic [HW:0]   sum0;
    logic [HW:0]   sumc;
    logic [HW-1:0] slot0;
    logic [HW-1:0] slotc;
    logic [HW-1:0] head_inc;
    logic [SAW-1:0] base;
    logic          full;

    always_comb begin
        sum0     = {1'b0, r_head};
        sumc     = {1'b0, r_head} + (HW + 1)'(r_count);
        slot0    = r_head;
        slotc    = (sumc >= (HW + 1)'(LOG_DEPTH)) ? HW'(sumc - (HW + 1)'(LOG_DEPTH))
                                                  : sumc[HW-1:0];
        head_inc = (sum0 + (HW + 1)'(1) == (HW + 1)'(LOG_DEPTH)) ? '0
                                                                 : HW'(sum0 + (HW + 1)'(1));
        base     = SAW'(r_user) * SAW'(LOG_DEPTH);
        full     = (r_count == CW'(LOG_DEPTH));
        stamp_raddr = base + SAW'(slot0);
        stamp_waddr = full ? stamp_raddr : base + SAW'(slotc);
    end

    logic expired;
    assign expired = (r_now >= stamp_rdata) && ((r_now - stamp_rdata) > TW'(r_window));

    // final record and status
    logic [TW:0]       mute_sum;
    logic [TW-1:0]     mute_time;
    logic              over;
    logic [HW-1:0]     f_head;
    logic [CW-1:0]     f_count;
    logic              f_valid;
    logic [TW-1:0]     f_exp;
    swfl_pkg::t_status f_status;

    always_comb begin
        mute_sum  = {1'b0, r_now} + (TW + 1)'(r_mute);
        mute_time = mute_sum[TW] ? '1 : mute_sum[TW-1:0];
        over      = CMPW'(r_count) > CMPW'(r_max);
        f_head    = r_head;
        f_count   = r_count;
        f_valid   = r_valid;
        f_exp     = r_exp;
        f_status  = swfl_pkg::ST_NO_CHANGE;
        case (r_op)
            swfl_pkg::OP_CHAT: begin
                if (!r_exempt) begin
                    if (r_valid) begin
                        f_status = swfl_pkg::ST_BLOCKED;
                    end else if (over) begin
                        f_valid  = 1'b1;
                        f_exp    = mute_time;
                        f_head   = '0;
                        f_count  = '0;
                        f_status = swfl_pkg::ST_MUTED_NOW;
                    end else begin
                        f_status = swfl_pkg::ST_PASSED;
                    end
                end
            end
            swfl_pkg::OP_CHECK: begin
                if (r_valid && r_now >= r_exp) begin
                    f_valid  = 1'b0;
                    f_exp    = '0;
                    f_status = swfl_pkg::ST_UNMUTED;
                end
            end
            swfl_pkg::OP_LOGIN: begin
                if (r_mark && !r_valid) begin
                    f_valid  = 1'b1;
                    f_exp    = mute_time;
                    f_status = swfl_pkg::ST_RESTORED;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear) begin
            r_clr <= r_clr + UW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op     <= i_op;
            r_user   <= user_map[i_user_index];
            r_now    <= i_now_seconds;
            r_mark   <= i_mute_mark_present;
            r_exempt <= i_exempt;
        end
        if (i_cmd.load_user) begin
            {r_head, r_count, r_valid, r_exp} <= user_rdata;
        end else if (i_cmd.pop_chk && expired) begin
            r_head  <= head_inc;
            r_count <= r_count - CW'(1);
        end else if (i_cmd.append) begin
            if (full) begin
                r_head <= head_inc;
            end else begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    assign user_we    = i_cmd.clear || i_cmd.commit;
    assign user_waddr = i_cmd.clear ? r_clr : r_user;
    assign user_wdata = i_cmd.clear ? '0 : {f_head, f_count, f_valid, f_exp};

    swfl_ram #(
        .WIDTH(RECW),
        .DEPTH(USERS)
    ) u_user_ram (
        .i_clk  (i_clk),
        .i_we   (user_we),
        .i_waddr(user_waddr),
        .i_wdata(user_wdata),
        .i_raddr(user_map[i_user_index]),
        .o_rdata(user_rdata)
    );

    swfl_ram #(
        .WIDTH(TW),
        .DEPTH(SDEPTH)
    ) u_stamp_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.append),
        .i_waddr(stamp_waddr),
        .i_wdata(r_now),
        .i_raddr(stamp_raddr),
        .o_rdata(stamp_rdata)
    );

    logic                          r_out_valid;
    logic [swfl_pkg::STATUS_W-1:0] r_status;
    logic [TW-1:0]                 r_mute_until;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status     <= f_status;
            r_mute_until <= f_valid ? f_exp : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_mute_until = r_mute_until;

    assign o_stat.clear_last = (r_clr == UW'(USERS - 1));
    assign o_stat.path_chat  = (r_op == swfl_pkg::OP_CHAT) && !r_exempt && !r_valid;
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.count_one  = (r_count == CW'(1));
    assign o_stat.expired    = expired;
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

endmodule
